FILE: rtl/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int ENTRY_W       = 16;
  localparam int INDEX_W       = 5;
  localparam int COUNT_W       = 6;
  localparam int DEFAULT_DEPTH = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [INDEX_W-1:0]        entry_index;
    logic signed [ENTRY_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] position;
  } rsp_item_t;

endpackage

FILE: rtl/stbs_table_mem.sv
// ----------------------------------------------------------------------------
// stbs_table_mem
// Table storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module stbs_table_mem #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_DEPTH,
  parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [AW-1:0]                      wr_addr,
  input  logic signed [stbs_pkg::ENTRY_W-1:0] wr_data,
  input  logic                               rd_en,
  input  logic [AW-1:0]                      rd_addr,
  output logic signed [stbs_pkg::ENTRY_W-1:0] rd_data
);

  logic signed [stbs_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/stbs_search_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_search_ctrl
// Request handling, bisection sequencer and result register.
// ----------------------------------------------------------------------------
module stbs_search_ctrl #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_DEPTH,
  parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  stbs_pkg::req_item_t                 req_item,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output stbs_pkg::rsp_item_t                 rsp_item,
  input  logic [stbs_pkg::COUNT_W-1:0]        used_count,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic signed [stbs_pkg::ENTRY_W-1:0] wr_data,
  output logic                                rd_en,
  output logic [AW-1:0]                       rd_addr,
  input  logic signed [stbs_pkg::ENTRY_W-1:0] rd_data
);

  localparam int IW = stbs_pkg::COUNT_W;
  localparam int XW = (AW > IW) ? AW : IW;
  localparam logic [XW-1:0] LAST_X = XW'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_STEP  = 3'b010,
    S_FINAL = 3'b100
  } state_t;

  state_t state, state_next;

  logic [IW-1:0]                       lo, hi, mid;
  logic [IW-1:0]                       lo_next, hi_next, mid_next;
  logic signed [stbs_pkg::ENTRY_W-1:0] key;

  logic          accept, is_search, more, load_out;
  logic [IW-1:0] count_m1, hi_init;
  logic [XW-1:0] count_m1_x, hi_init_x, idx_x, mid_x;
  logic [IW:0]   sum;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign is_search = (req_item.op == stbs_pkg::OP_SEARCH);

  // A count of zero searches entry zero; counts past the depth saturate.
  assign count_m1   = (used_count == '0) ? '0 : used_count - IW'(1);
  assign count_m1_x = XW'(count_m1);
  assign hi_init_x  = (count_m1_x > LAST_X) ? LAST_X : count_m1_x;
  assign hi_init    = hi_init_x[IW-1:0];

  assign idx_x   = XW'(req_item.entry_index);
  assign wr_en   = accept && !is_search && (32'(req_item.entry_index) < TABLE_DEPTH);
  assign wr_addr = idx_x[AW-1:0];
  assign wr_data = req_item.value;

  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (state == S_IDLE) begin
      lo_next = '0;
      hi_next = hi_init;
    end else if (state == S_STEP) begin
      if (key > rd_data) begin
        lo_next = mid + IW'(1);
      end else begin
        hi_next = mid;
      end
    end
  end

  // When the range has closed, the next read fetches the final entry.
  assign more     = (lo_next < hi_next);
  assign sum      = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_next = more ? sum[IW:1] : lo_next;
  assign mid_x    = XW'(mid_next);
  assign rd_addr  = mid_x[AW-1:0];
  assign rd_en    = (accept && is_search) || (state == S_STEP);

  assign load_out = (state == S_FINAL) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && is_search) begin
          state_next = more ? S_STEP : S_FINAL;
        end
      end
      S_STEP: begin
        state_next = more ? S_STEP : S_FINAL;
      end
      S_FINAL: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
    end
    if (accept && is_search) begin
      key <= req_item.value;
    end
    if (load_out) begin
      rsp_item.found    <= (rd_data == key);
      rsp_item.position <= lo[stbs_pkg::INDEX_W-1:0];
    end
  end

endmodule

FILE: rtl/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Lower-bound binary search over a software-written table of signed entries.
// ----------------------------------------------------------------------------
// A write item stores one entry. A search item is
// accepted, then bisects the first used_count entries with one table memory
// read per step, and ends with one more read of the final position to set the
// found flag. Once its result is loaded into the output register, the next
// item is accepted in the cycle after. The load waits while an earlier result
// still sits stalled in the output register. The bisection steps share the
// single read port of the table. A finished result may wait in the output
// register while the next item is taken in. A used_count of zero searches
// entry zero alone, and a count above the table depth is limited to the depth.
// Configuration writes are always taken.
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  stbs_pkg::req_item_t          req_item,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output stbs_pkg::rsp_item_t          rsp_item,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [stbs_pkg::COUNT_W-1:0] cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [stbs_pkg::COUNT_W-1:0]        used_count;
  logic                                wr_en, rd_en;
  logic [AW-1:0]                       wr_addr, rd_addr;
  logic signed [stbs_pkg::ENTRY_W-1:0] wr_data, rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= stbs_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      used_count <= cfg_data;
    end
  end

  stbs_search_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_item   (req_item),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp_item   (rsp_item),
    .used_count (used_count),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  stbs_table_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

FILE: verif/lower_bound_checker.sv
// ----------------------------------------------------------------------------
// lower_bound_checker
// Watches the search, result and used-count channels of the sorted table
// binary search core, keeps its own copy of the table and the used count,
// predicts each search result and compares it field by field.
// ----------------------------------------------------------------------------
module lower_bound_checker
  import stbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  req_item_t          req_item,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  rsp_item_t          rsp_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending_results
);

  logic signed [ENTRY_W-1:0] table_copy [DEFAULT_DEPTH] = '{default: '0};
  logic [COUNT_W-1:0]        count_copy = COUNT_RESET;
  rsp_item_t                 expected_lookups [$];
  rsp_item_t                 oldest;
  int                        mismatches = 0;

  function automatic rsp_item_t predict_lower_bound(input logic signed [ENTRY_W-1:0] key);
    int        span;
    int        lo;
    int        hi;
    int        mid;
    rsp_item_t r;
    span = (count_copy == 0) ? 1 :
           ((count_copy > DEFAULT_DEPTH) ? DEFAULT_DEPTH : int'(count_copy));
    lo = 0;
    hi = span - 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (key > table_copy[mid]) lo = mid + 1;
      else hi = mid;
    end
    r.found    = (table_copy[lo] == key);
    r.position = INDEX_W'(lo);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_lookups.delete();
      count_copy = COUNT_RESET;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch($sformatf("result with no search waiting (found %0b position %0d)",
                                    rsp_item.found, rsp_item.position));
        end else begin
          oldest = expected_lookups.pop_front();
          if (rsp_item.found !== oldest.found)
            report_mismatch($sformatf("found is %0b, expected %0b", rsp_item.found,
                                      oldest.found));
          if (rsp_item.position !== oldest.position)
            report_mismatch($sformatf("position is %0d, expected %0d", rsp_item.position,
                                      oldest.position));
        end
      end
      if (cfg_valid && cfg_ready) count_copy = cfg_data;
      if (req_valid && !req_stall) begin
        if (req_item.op == OP_WRITE) table_copy[req_item.entry_index] = req_item.value;
        else expected_lookups.push_back(predict_lower_bound(req_item.value));
      end
    end
    fail_count      <= mismatches;
    pending_results <= expected_lookups.size();
  end

endmodule

FILE: verif/tb_sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search_core
// Drives table writes, searches and used-count changes into the core under
// random idling on both channels and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search_core;
  import stbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASES         = 12;
  localparam int SEARCHES       = 100;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  req_item_t          req_item  = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rsp_item_t          rsp_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending_results;

  int req_idle_pct   = 30;
  int rsp_idle_pct   = 76;
  int hold_requests  = 0;
  int holds_started  = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int count_now      = 32;
  int table_img [DEFAULT_DEPTH];

  // A negative entry means a random count for that phase.
  int count_plan [PHASES] = '{32, 1, 63, 2, 17, 0, 33, -1, 31, 32, -1, 5};

  always #1 clk = ~clk;

  sorted_table_binary_search_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lower_bound_checker lookup_check (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req_item        (req_item),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp_item        (rsp_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_requests != holds_started) begin
      holds_started <= hold_requests;
      hold_left     <= HOLD_CYCLES - 1;
      rsp_stall     <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(input req_item_t it);
    req_valid <= 1'b1;
    req_item  <= it;
    do @(posedge clk); while (req_stall);
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_write(input int idx, input int val);
    req_item_t it;
    it.op          = OP_WRITE;
    it.entry_index = INDEX_W'(idx);
    it.value       = ENTRY_W'(val);
    table_img[idx] = val;
    send_item(it);
  endtask

  task automatic send_search(input int key);
    req_item_t it;
    it.op          = OP_SEARCH;
    it.entry_index = INDEX_W'($urandom_range(0, DEFAULT_DEPTH - 1));
    it.value       = ENTRY_W'(key);
    send_item(it);
  endtask

  // Stops offering items until every search has returned, then lets the core
  // settle for as long as the extra argument asks.
  task automatic wait_drained(input int extra);
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_used_count(input int n);
    cfg_valid <= 1'b1;
    cfg_data  <= COUNT_W'(n);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_now = n;
  endtask

  // Fills the whole table in ascending order: wide steps, runs of duplicates,
  // or a spread from the most negative to the most positive value.
  task automatic load_sorted_table();
    int mode;
    int v;
    int step_max;
    mode = $urandom_range(0, 2);
    v = int'($urandom_range(0, 65535)) - 32768;
    step_max = (mode == 0) ? 64 : 2;
    if (mode == 2) begin
      v = -32768;
      step_max = 2114;
    end
    for (int i = 0; i < DEFAULT_DEPTH; i++) begin
      if (mode == 2 && i == DEFAULT_DEPTH - 1) v = 32767;
      send_write(i, v);
      v += $urandom_range(0, step_max);
      if (v > 32767) v = 32767;
    end
  endtask

  function automatic int pick_key();
    int span;
    int r;
    int k;
    span = (count_now == 0) ? 1 : ((count_now > DEFAULT_DEPTH) ? DEFAULT_DEPTH : count_now);
    r = $urandom_range(0, 99);
    k = table_img[$urandom_range(0, span - 1)];
    if (r < 50) return k;
    if (r < 70) begin
      k += $urandom_range(0, 1) ? 1 : -1;
      if (k > 32767) k = 32767;
      if (k < -32768) k = -32768;
      return k;
    end
    if (r < 80) return $urandom_range(0, 1) ? 32767 : -32768;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part on a four-entry table, so every read entry is written.
    write_used_count(4);
    send_write(0, -32768);
    send_write(1, -5);
    send_write(2, 7);
    send_write(3, 32767);
    send_search(-32768);
    send_search(32767);
    send_search(0);
    send_search(-5);
    send_search(-6);
    send_search(8);
    send_search(-32767);
    send_search(7);
    wait_drained(12);
    // A count of zero searches entry zero alone.
    write_used_count(0);
    send_search(-32768);
    send_search(100);
    wait_drained(12);
    write_used_count(1);
    send_search(-32768);
    send_search(-32767);
    wait_drained(12);
    // Break the order of the table and search it anyway.
    write_used_count(4);
    send_write(1, 30000);
    send_search(7);
    send_search(30000);
    send_search(-5);

    for (int p = 0; p < PHASES; p++) begin
      if (p < PHASES / 3) begin
        req_idle_pct = 30;
        rsp_idle_pct = 76;
      end else if (p < 2 * PHASES / 3) begin
        req_idle_pct = 76;
        rsp_idle_pct = 30;
      end else begin
        req_idle_pct = 0;
        rsp_idle_pct = 0;
      end
      wait_drained(12);
      write_used_count((count_plan[p] < 0) ? int'($urandom_range(1, 63)) : count_plan[p]);
      if (p == 0 || $urandom_range(0, 3) != 0) load_sorted_table();
      // Hold results back while searches keep coming, so the core backs up.
      if (p == PHASES - 3) hold_requests <= hold_requests + 1;
      repeat (SEARCHES) begin
        if ($urandom_range(0, 99) < 5)
          send_write($urandom_range(0, DEFAULT_DEPTH - 1), int'($urandom_range(0, 65535)) - 32768);
        else
          send_search(pick_key());
      end
    end

    wait_drained(20);
    if (fail_count == 0 && pending_results == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
